[hdl/tun_pkg.sv]
// Shared transaction types and fixed constants of the triangle unit-normal pipeline.
package tun_pkg;

    localparam int FIELD_W       = 16;
    localparam int NORM_W        = 16;
    localparam int OUT_FIELD_MAX = 32767;

    typedef struct packed {
        logic signed [FIELD_W-1:0] a_x;
        logic signed [FIELD_W-1:0] a_y;
        logic signed [FIELD_W-1:0] a_z;
        logic signed [FIELD_W-1:0] b_x;
        logic signed [FIELD_W-1:0] b_y;
        logic signed [FIELD_W-1:0] b_z;
        logic signed [FIELD_W-1:0] c_x;
        logic signed [FIELD_W-1:0] c_y;
        logic signed [FIELD_W-1:0] c_z;
    } tun_in_t;

    typedef struct packed {
        logic signed [NORM_W-1:0] norm_x;
        logic signed [NORM_W-1:0] norm_y;
        logic signed [NORM_W-1:0] norm_z;
        logic                     degenerate;
    } tun_out_t;

    // Control that travels alongside the wide datapath.
    typedef struct packed {
        logic       valid;
        logic       degenerate;
        logic [2:0] neg;
    } tun_tag_t;

endpackage

[hdl/triangle_unit_normal.sv]
// Top level of the pipelined triangle unit-normal unit.
//
// One triangle (three vertices, signed Q8.8) enters per clock and the unit face normal
// (signed Q1.14, rounded to nearest with ties away from zero, saturated at +/-2^F, or at
// +/-32767 when F is 15 or more) leaves after edges and the exact cross product, squaring
// and the sum of squares, the root search (one result bit per stage) and rounding into the
// output register. Throughput is one triangle per cycle; the whole pipeline holds while a
// result waits on m_ready. A triangle whose cross product is zero gives a zero normal with
// degenerate set.
module triangle_unit_normal #(
    parameter int COORD_WIDTH      = 16,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tun_pkg::tun_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output tun_pkg::tun_out_t m_data
);

    localparam int  F   = NORMAL_FRAC_BITS;
    localparam int  MW  = 2 * COORD_WIDTH + 2;
    localparam int  QW  = 2 * MW;
    localparam int  SW  = 2 * MW + 2;
    localparam int  TB  = F + 2;
    localparam int  NW  = tun_pkg::NORM_W;
    localparam longint CAP = (F >= 15) ? longint'(tun_pkg::OUT_FIELD_MAX) : (64'sd1 <<< F);

    logic                en;
    logic                x_valid;
    logic [MW-1:0]       x_mag [3];
    logic [2:0]          x_neg;
    logic                x_zero;
    tun_pkg::tun_tag_t   x_tag;
    tun_pkg::tun_tag_t   q_tag;
    logic [QW-1:0]       q_sq [3];
    logic [SW-1:0]       q_sum;
    tun_pkg::tun_tag_t   r_tag;
    logic [TB-1:0]       r_quo [3];

    logic [TB:0]         rnd [3];
    logic [TB-1:0]       lim [3];
    logic [NW-1:0]       comp [3];
    tun_pkg::tun_out_t   res;

    logic                m_valid_reg;
    tun_pkg::tun_out_t   m_data_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    tun_cross #(.CW(COORD_WIDTH), .MW(MW)) u_cross (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(s_valid && s_ready), .in_data(s_data),
        .out_valid(x_valid), .mag(x_mag), .neg(x_neg), .zero(x_zero)
    );

    assign x_tag = '{valid: x_valid, degenerate: x_zero, neg: x_neg};

    tun_square #(.MW(MW), .QW(QW), .SW(SW)) u_square (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_tag(x_tag), .mag(x_mag),
        .out_tag(q_tag), .sq(q_sq), .sum(q_sum)
    );

    tun_root #(.F(F), .QW(QW), .SW(SW), .TB(TB)) u_root (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_tag(q_tag), .sq(q_sq), .sum(q_sum),
        .out_tag(r_tag), .quo(r_quo)
    );

    // The search yields twice the scaled value, so one more bit gives the rounding.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rnd[i]  = {1'b0, r_quo[i]} + (TB+1)'(1);
            lim[i]  = (rnd[i][TB:1] > TB'(CAP)) ? TB'(CAP) : rnd[i][TB:1];
            comp[i] = r_tag.neg[i] ? NW'(-NW'(lim[i])) : NW'(lim[i]);
            if (r_tag.degenerate) begin
                comp[i] = '0;
            end
        end
        res.norm_x     = comp[0];
        res.norm_y     = comp[1];
        res.norm_z     = comp[2];
        res.degenerate = r_tag.degenerate;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= r_tag.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_degenerate_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.degenerate |->
            m_data.norm_x == '0 && m_data.norm_y == '0 && m_data.norm_z == '0)
        else $error("degenerate result with a non-zero normal");

    a_norm_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |->
            longint'(m_data.norm_x) <= CAP && longint'(m_data.norm_x) >= -CAP &&
            longint'(m_data.norm_y) <= CAP && longint'(m_data.norm_y) >= -CAP &&
            longint'(m_data.norm_z) <= CAP && longint'(m_data.norm_z) >= -CAP)
        else $error("normal component beyond the saturation limit");

    a_nonzero_normal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.degenerate |->
            m_data.norm_x != '0 || m_data.norm_y != '0 || m_data.norm_z != '0)
        else $error("non-degenerate result with an all-zero normal");
`endif

endmodule

[hdl/tun_cross.sv]
// Edge subtraction and exact cross product, giving sign and magnitude per component.
module tun_cross #(
    parameter int CW = 16,
    parameter int MW = 2 * CW + 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  tun_pkg::tun_in_t  in_data,
    output logic              out_valid,
    output logic [MW-1:0]     mag [3],
    output logic [2:0]        neg,
    output logic              zero
);

    localparam int EW = CW + 1;
    localparam int PW = 2 * EW;
    localparam int DW = PW + 1;

    logic [tun_pkg::FIELD_W-1:0] fld [9];
    logic signed [CW-1:0]        crd [9];

    logic signed [EW-1:0] e1_reg [3];
    logic signed [EW-1:0] e2_reg [3];
    logic signed [PW-1:0] p_reg [3];
    logic signed [PW-1:0] q_reg [3];
    logic signed [DW-1:0] d_reg [3];
    logic [MW-1:0]        mag_reg [3];
    logic [2:0]           neg_reg;
    logic                 zero_reg;
    logic [3:0]           v_reg;

    assign fld[0] = in_data.a_x;
    assign fld[1] = in_data.a_y;
    assign fld[2] = in_data.a_z;
    assign fld[3] = in_data.b_x;
    assign fld[4] = in_data.b_y;
    assign fld[5] = in_data.b_z;
    assign fld[6] = in_data.c_x;
    assign fld[7] = in_data.c_y;
    assign fld[8] = in_data.c_z;

    // Only the low CW bits of a field form the coordinate; a field narrower than CW is zero-extended.
    for (genvar k = 0; k < 9; k++) begin : g_crd
        if (CW <= tun_pkg::FIELD_W) begin : g_narrow
            assign crd[k] = fld[k][CW-1:0];
        end else begin : g_wide
            assign crd[k] = {{(CW - tun_pkg::FIELD_W){1'b0}}, fld[k]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                e1_reg[i] <= $signed({crd[3+i][CW-1], crd[3+i]}) - $signed({crd[i][CW-1], crd[i]});
                e2_reg[i] <= $signed({crd[6+i][CW-1], crd[6+i]}) - $signed({crd[i][CW-1], crd[i]});
            end
            p_reg[0] <= e1_reg[1] * e2_reg[2];
            q_reg[0] <= e1_reg[2] * e2_reg[1];
            p_reg[1] <= e1_reg[2] * e2_reg[0];
            q_reg[1] <= e1_reg[0] * e2_reg[2];
            p_reg[2] <= e1_reg[0] * e2_reg[1];
            q_reg[2] <= e1_reg[1] * e2_reg[0];
            for (int i = 0; i < 3; i++) begin
                d_reg[i] <= $signed({p_reg[i][PW-1], p_reg[i]})
                          - $signed({q_reg[i][PW-1], q_reg[i]});
            end
            for (int i = 0; i < 3; i++) begin
                mag_reg[i] <= d_reg[i][DW-1] ? MW'(-d_reg[i]) : MW'(d_reg[i]);
                neg_reg[i] <= d_reg[i][DW-1];
            end
            zero_reg <= (d_reg[0] == '0) && (d_reg[1] == '0) && (d_reg[2] == '0);
        end
    end

    assign out_valid = v_reg[3];
    assign mag       = mag_reg;
    assign neg       = neg_reg;
    assign zero      = zero_reg;

endmodule

[hdl/tun_square.sv]
// Squares of the cross product components, split into half-width products, and their sum.
module tun_square #(
    parameter int MW = 34,
    parameter int QW = 2 * MW,
    parameter int SW = 2 * MW + 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  tun_pkg::tun_tag_t in_tag,
    input  logic [MW-1:0]     mag [3],
    output tun_pkg::tun_tag_t out_tag,
    output logic [QW-1:0]     sq [3],
    output logic [SW-1:0]     sum
);

    localparam int K = MW / 2;
    localparam int H = MW - K;

    logic [2*H-1:0]   hh_reg [3];
    logic [H+K-1:0]   hl_reg [3];
    logic [2*K-1:0]   ll_reg [3];
    logic [QW-1:0]    sq_reg [3];
    logic [QW-1:0]    sq2_reg [3];
    logic [SW-1:0]    sum_reg;
    tun_pkg::tun_tag_t tag_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < 3; j++) begin
                tag_reg[j].valid <= 1'b0;
            end
        end else if (en) begin
            tag_reg[0] <= in_tag;
            tag_reg[1] <= tag_reg[0];
            tag_reg[2] <= tag_reg[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                hh_reg[i]  <= mag[i][MW-1:K] * mag[i][MW-1:K];
                hl_reg[i]  <= mag[i][MW-1:K] * mag[i][K-1:0];
                ll_reg[i]  <= mag[i][K-1:0] * mag[i][K-1:0];
                sq_reg[i]  <= (QW'(hh_reg[i]) << (2 * K)) + (QW'(hl_reg[i]) << (K + 1))
                            + QW'(ll_reg[i]);
                sq2_reg[i] <= sq_reg[i];
            end
            sum_reg <= SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);
        end
    end

    assign out_tag = tag_reg[2];
    assign sq      = sq2_reg;
    assign sum     = sum_reg;

endmodule

[hdl/tun_root.sv]
// Bit-per-stage search for floor(2^(F+1) * |n| / sqrt(S)) in three parallel lanes.
module tun_root #(
    parameter int F  = 14,
    parameter int QW = 68,
    parameter int SW = 70,
    parameter int TB = F + 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  tun_pkg::tun_tag_t in_tag,
    input  logic [QW-1:0]     sq [3],
    input  logic [SW-1:0]     sum,
    output tun_pkg::tun_tag_t out_tag,
    output logic [TB-1:0]     quo [3]
);

    localparam int RW = SW + 2 * F + 5;
    localparam int NS = F + 2;

    // Per lane: r is the remaining target, p is t * S, t the bits found so far.
    logic [RW-1:0]     r_in  [NS][3];
    logic [RW-1:0]     p_in  [NS][3];
    logic [TB-1:0]     t_in  [NS][3];
    logic [RW-1:0]     s_in  [NS];
    tun_pkg::tun_tag_t g_in  [NS];

    logic [RW-1:0]     r_reg [NS][3];
    logic [RW-1:0]     p_reg [NS][3];
    logic [TB-1:0]     t_reg [NS][3];
    logic [RW-1:0]     s_reg [NS];
    tun_pkg::tun_tag_t g_reg [NS];

    for (genvar j = 0; j < NS; j++) begin : g_stage
        localparam int B = F + 1 - j;

        logic [RW-1:0] inc  [3];
        logic [2:0]    take;

        if (j == 0) begin : g_first
            for (genvar i = 0; i < 3; i++) begin : g_lane
                assign r_in[j][i] = RW'(sq[i]) << (2 * F + 2);
                assign p_in[j][i] = '0;
                assign t_in[j][i] = '0;
            end
            assign s_in[j] = RW'(sum);
            assign g_in[j] = in_tag;
        end else begin : g_next
            assign r_in[j] = r_reg[j-1];
            assign p_in[j] = p_reg[j-1];
            assign t_in[j] = t_reg[j-1];
            assign s_in[j] = s_reg[j-1];
            assign g_in[j] = g_reg[j-1];
        end

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                inc[i]  = (p_in[j][i] << (B + 1)) + (s_in[j] << (2 * B));
                take[i] = (inc[i] <= r_in[j][i]);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                g_reg[j].valid <= 1'b0;
            end else if (en) begin
                g_reg[j] <= g_in[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                s_reg[j] <= s_in[j];
                for (int i = 0; i < 3; i++) begin
                    r_reg[j][i] <= take[i] ? r_in[j][i] - inc[i] : r_in[j][i];
                    p_reg[j][i] <= take[i] ? p_in[j][i] + (s_in[j] << B) : p_in[j][i];
                    t_reg[j][i] <= t_in[j][i] | (TB'(take[i]) << B);
                end
            end
        end
    end

    assign out_tag = g_reg[NS-1];
    assign quo     = t_reg[NS-1];

endmodule
